// File: src/mbt_pkg.sv
package mbt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MAC_W = 48;
  localparam int IP_W = 32;

  localparam logic [1:0] CMD_LEARN = 2'd0;
  localparam logic [1:0] CMD_LOOKUP_IP = 2'd1;
  localparam logic [1:0] CMD_LOOKUP_MAC = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } entry_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IP_W-1:0]  found_ip;
    logic [MAC_W-1:0] found_mac;
    logic             hit;
  } result_t;

endpackage

// File: src/mbt_table_ram.sv
module mbt_table_ram
  import mbt_pkg::*;
#(
  parameter int DEPTH = TABLE_ENTRIES_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/mbt_ctrl.sv
module mbt_ctrl
  import mbt_pkg::*;
#(
  parameter int DEPTH = TABLE_ENTRIES_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [MAC_W-1:0] in_mac,
  input  logic [IP_W-1:0]  in_ip,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  entry_t           rd_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output entry_t           wr_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [1:0]       state;
  logic [AW-1:0]    addr;
  logic             issued_all;
  logic             rd_pend;
  logic [AW-1:0]    rd_idx;
  logic             clr_flush;

  logic [1:0]       cmd;
  logic [MAC_W-1:0] cmd_mac;
  logic [IP_W-1:0]  cmd_ip;

  logic             found;
  logic [AW-1:0]    found_idx;
  logic [MAC_W-1:0] found_mac;
  logic [IP_W-1:0]  found_ip;
  logic             have_free;
  logic [AW-1:0]    free_idx;

  logic             mac_eq;
  logic             ip_eq;
  logic             wipe;
  logic             finish_go;

  assign in_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_FINISH);
  assign finish_go = res_valid && res_ready;

  assign mac_eq = rd_data.valid && (rd_data.mac == cmd_mac);
  assign ip_eq = rd_data.valid && (rd_data.ip == cmd_ip);
  // learn drops every other slot that holds the same ip
  assign wipe = rd_pend && (cmd == CMD_LEARN) && ip_eq && !mac_eq;

  assign rd_en = (state == ST_SCAN) && !issued_all;
  assign rd_addr = addr;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = addr;
    wr_data = '{valid: 1'b1, mac: cmd_mac, ip: cmd_ip};
    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_data.valid = 1'b0;
      end
      ST_SCAN: begin
        wr_en = wipe;
        wr_addr = rd_idx;
        wr_data = rd_data;
        wr_data.valid = 1'b0;
      end
      ST_FINISH: begin
        if (cmd == CMD_LEARN) begin
          if (found) begin
            wr_en = finish_go && (found_ip != cmd_ip);
            wr_addr = found_idx;
          end else begin
            wr_en = finish_go && have_free;
            wr_addr = free_idx;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res = '{status: STATUS_DONE, found_ip: '0, found_mac: '0, hit: 1'b0};
    unique case (cmd)
      CMD_LEARN: begin
        if (found) begin
          res.hit = 1'b1;
          res.found_mac = cmd_mac;
          res.found_ip = cmd_ip;
        end else if (!have_free) begin
          res.status = STATUS_FULL;
        end
      end
      CMD_LOOKUP_IP, CMD_LOOKUP_MAC: begin
        if (found) begin
          res.hit = 1'b1;
          res.found_mac = found_mac;
          res.found_ip = found_ip;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      CMD_FLUSH: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr <= '0;
      clr_flush <= 1'b0;
      issued_all <= 1'b0;
      rd_pend <= 1'b0;
      found <= 1'b0;
      have_free <= 1'b0;
      cmd <= CMD_FLUSH;
    end else begin
      rd_pend <= rd_en;
      rd_idx <= addr;
      unique case (state)
        ST_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == LAST_ADDR) begin
            state <= clr_flush ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd <= in_cmd;
            cmd_mac <= in_mac;
            cmd_ip <= in_ip;
            addr <= '0;
            issued_all <= 1'b0;
            found <= 1'b0;
            have_free <= 1'b0;
            clr_flush <= 1'b1;
            state <= (in_cmd == CMD_FLUSH) ? ST_CLEAR : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            addr <= addr + 1'b1;
            if (addr == LAST_ADDR) begin
              issued_all <= 1'b1;
            end
          end
          if (rd_pend) begin
            unique case (cmd)
              CMD_LEARN: begin
                if (mac_eq) begin
                  if (!found) begin
                    found <= 1'b1;
                    found_idx <= rd_idx;
                    found_ip <= rd_data.ip;
                  end
                end else if ((!rd_data.valid || ip_eq) && !have_free) begin
                  // first slot that is free once the wipe is done
                  have_free <= 1'b1;
                  free_idx <= rd_idx;
                end
              end
              CMD_LOOKUP_IP: begin
                if (ip_eq && !found) begin
                  found <= 1'b1;
                  found_mac <= rd_data.mac;
                  found_ip <= rd_data.ip;
                end
              end
              CMD_LOOKUP_MAC: begin
                if (mac_eq && !found) begin
                  found <= 1'b1;
                  found_mac <= rd_data.mac;
                  found_ip <= rd_data.ip;
                end
              end
              CMD_FLUSH: begin
              end
            endcase
            if (issued_all) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: src/mac_ip_binding_table_core.sv
// channel  dir  tdata fields (lowest bit first)
// s_*      in   cmd[1:0], mac_addr[49:2], ip_addr[81:50], zero pad to 88 bits
// m_*      out  hit[0], found_mac[48:1], found_ip[80:49], status[82:81], zero pad
//
// each command, from its transfer to a loaded result, makes one pass over the table ram,
// one read a cycle, then goes through a write-back state
// flush sweeps the ram writing one entry a cycle in place of the read pass
// after rst a clearing pass over all TABLE_ENTRIES entries runs before s_tready rises
// the result register lets the next command start while m_tready is low;
// a finished command waits in its write-back state until that register is free
module mac_ip_binding_table_core
  import mbt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // cmd, mac_addr, ip_addr
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // hit, found_mac, found_ip, status
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_res;

  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata = {5'b0, out_res};

  mbt_table_ram #(
    .DEPTH(TABLE_ENTRIES),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  mbt_ctrl #(
    .DEPTH(TABLE_ENTRIES),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_cmd(s_tdata[1:0]),
    .in_mac(s_tdata[49:2]),
    .in_ip(s_tdata[81:50]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule
